>>> hdl/gold_code_sliding_correlator_macros.svh
// Assertion macros for the Gold code sliding correlator.
// Included by the RTL files that carry concurrent checks; no dependencies.
`ifndef GOLD_CODE_SLIDING_CORRELATOR_MACROS_SVH
`define GOLD_CODE_SLIDING_CORRELATOR_MACROS_SVH

`ifndef SYNTHESIS

`define GCSC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define GCSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define GCSC_ASSERT(label, clk, rst_n, prop, msg)

`define GCSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> hdl/gcsc_pkg.sv
// Shared constants, types and code generator functions for the Gold code correlator.
// No dependencies; imported by the interfaces and the top level.
`default_nettype none

package gcsc_pkg;

  localparam int unsigned CODE_LEN = 1023;
  localparam int unsigned PHASE_W  = 10;
  localparam int unsigned TAP_W    = 4;
  localparam int unsigned THR_W    = 17;
  localparam int unsigned CORR_W   = 18;
  localparam int unsigned CFG_W    = 17;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int CORR_MAX = 131071;
  localparam int CORR_MIN = -131072;

  localparam logic [PHASE_W-1:0] LFSR_INIT      = 10'h3FF;
  localparam logic [TAP_W-1:0]   TAP_FIRST_RST  = 4'd2;
  localparam logic [TAP_W-1:0]   TAP_SECOND_RST = 4'd6;
  localparam logic [THR_W-1:0]   THR_RST        = 17'd828;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TAP_FIRST  = 2'd0,
    CFG_TAP_SECOND = 2'd1,
    CFG_DETECT_THR = 2'd2
  } cfg_idx_e;

  typedef logic [PHASE_W-1:0] lfsr_t;

  // one-based G2 stage, zero when the tap selects no stage
  function automatic logic stage_bit(lfsr_t g2, logic [TAP_W-1:0] tap);
    logic b;
    b = 1'b0;
    if (tap inside {[4'd1:4'd10]}) begin
      b = g2[tap - 4'd1];
    end
    return b;
  endfunction

  function automatic lfsr_t g1_next(lfsr_t g1);
    return {g1[8:0], g1[2] ^ g1[9]};
  endfunction

  function automatic lfsr_t g2_next(lfsr_t g2);
    return {g2[8:0], g2[1] ^ g2[2] ^ g2[5] ^ g2[7] ^ g2[8] ^ g2[9]};
  endfunction

  function automatic logic code_chip(lfsr_t g1, lfsr_t g2,
                                     logic [TAP_W-1:0] tap_a, logic [TAP_W-1:0] tap_b);
    return g1[9] ^ stage_bit(g2, tap_a) ^ stage_bit(g2, tap_b);
  endfunction

  function automatic lfsr_t ring_inc(lfsr_t p);
    return (p == lfsr_t'(CODE_LEN - 1)) ? '0 : p + lfsr_t'(1);
  endfunction

endpackage

`default_nettype wire

>>> hdl/gcsc_if.sv
// Valid/ready stream interfaces for sample beats and result beats.
// Depends on gcsc_pkg for the result field widths.
`default_nettype none

interface gcsc_sample_if #(
  parameter int unsigned W = 8
);
  logic         valid;
  logic         ready;
  logic [W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface gcsc_result_if;
  import gcsc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [CORR_W-1:0]  correlation;
  logic [PHASE_W-1:0]        code_phase;
  logic                      detected;
  logic                      data_bit;

  modport source (output valid, output correlation, output code_phase,
                  output detected, output data_bit, input ready);
  modport sink   (input valid, input correlation, input code_phase,
                  input detected, input data_bit, output ready);
endinterface

`default_nettype wire

>>> hdl/gcsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module gcsc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> hdl/gold_code_sliding_correlator.sv
// Gold code sliding correlator top level: sample ring, code generator and serial accumulator.
// Depends on gcsc_pkg, gcsc_if, gcsc_ram and the assertion macro header.
`default_nettype none
`include "gold_code_sliding_correlator_macros.svh"

// Samples enter one beat at a time and go into a 1023-entry ring. While the
// ring fills, a sample is taken every cycle and gives no result. Once the ring
// is full every sample gives one result and holds the block busy while it is
// accepted, while the 1023 ring entries stream through the single ring read
// port and its registered read data into the shared add/subtract unit (one
// entry a cycle) until the read pipe is seen empty, and while the sum is
// saturated and compared. The G1/G2 code is regenerated chip by chip alongside.
// The result sits in an output register, so a result waiting to be taken stalls
// only the finishing cycle of the next sample. The ring needs no clearing after
// reset; the fill count keeps it from being read before it holds a full window.
// The user must write configuration only while idle; the block does not enforce it.
module gold_code_sliding_correlator #(
  parameter int unsigned SAMPLE_BITS = 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [gcsc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [gcsc_pkg::CFG_W-1:0]     cfg_data_i,
  gcsc_sample_if.sink                         sample_if,
  gcsc_result_if.source                       result_if
);
  import gcsc_pkg::*;

  localparam int unsigned ACC_W = SAMPLE_BITS + 10;
  localparam int unsigned CMP_W = ((ACC_W > CORR_W) ? ACC_W : CORR_W) + 1;
  localparam logic signed [CMP_W-1:0] SAT_HI = CMP_W'(CORR_MAX);
  localparam logic signed [CMP_W-1:0] SAT_LO = CMP_W'(CORR_MIN);
  localparam logic [PHASE_W:0] ISSUE_END = (PHASE_W + 1)'(CODE_LEN);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [TAP_W-1:0] tap_first_q, tap_second_q;
  logic [THR_W-1:0] thr_q;

  lfsr_t wp_q, wp_d;
  lfsr_t fill_q, fill_d;
  lfsr_t phase_q, phase_d;
  lfsr_t rd_addr_q, rd_addr_d;
  logic [PHASE_W:0] cnt_q, cnt_d;
  logic rd_vld_q, rd_vld_d;
  lfsr_t g1_q, g1_d, g2_q, g2_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;

  logic out_vld_q, out_vld_d;
  logic signed [CORR_W-1:0] corr_q, corr_d;
  logic [PHASE_W-1:0] oph_q, oph_d;
  logic det_q, det_d, bit_q, bit_d;

  logic accept, issue, load;
  logic [SAMPLE_BITS-1:0] rd_data;
  logic signed [ACC_W-1:0] s_ext;
  logic signed [CMP_W-1:0] sum_ext, thr_ext;

  gcsc_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(CODE_LEN)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (accept),
    .waddr_i(wp_q),
    .wdata_i(sample_if.sample[SAMPLE_BITS-1:0]),
    .re_i   (issue),
    .raddr_i(rd_addr_q),
    .rdata_o(rd_data)
  );

  assign sample_if.ready = (state_q == S_IDLE);
  assign accept = sample_if.valid && sample_if.ready;
  assign issue  = (state_q == S_RUN) && (cnt_q != ISSUE_END);
  assign load   = (state_q == S_DONE) && (!out_vld_q || result_if.ready);

  assign s_ext   = {{(ACC_W - SAMPLE_BITS){rd_data[SAMPLE_BITS-1]}}, rd_data};
  assign sum_ext = {{(CMP_W - ACC_W){acc_q[ACC_W-1]}}, acc_q};
  assign thr_ext = {{(CMP_W - THR_W){1'b0}}, thr_q};

  always_comb begin
    state_d   = state_q;
    wp_d      = wp_q;
    fill_d    = fill_q;
    phase_d   = phase_q;
    rd_addr_d = rd_addr_q;
    cnt_d     = cnt_q;
    rd_vld_d  = issue;
    g1_d      = g1_q;
    g2_d      = g2_q;
    acc_d     = acc_q;
    out_vld_d = out_vld_q && !result_if.ready;
    corr_d    = corr_q;
    oph_d     = oph_q;
    det_d     = det_q;
    bit_d     = bit_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          wp_d = ring_inc(wp_q);
          if (fill_q != lfsr_t'(CODE_LEN)) begin
            fill_d = fill_q + lfsr_t'(1);
          end
          if (fill_q >= lfsr_t'(CODE_LEN - 1)) begin
            rd_addr_d = ring_inc(wp_q);
            cnt_d     = '0;
            acc_d     = '0;
            g1_d      = LFSR_INIT;
            g2_d      = LFSR_INIT;
            state_d   = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (issue) begin
          rd_addr_d = ring_inc(rd_addr_q);
          cnt_d     = cnt_q + (PHASE_W + 1)'(1);
        end
        if (rd_vld_q) begin
          acc_d = code_chip(g1_q, g2_q, tap_first_q, tap_second_q) ? acc_q + s_ext
                                                                   : acc_q - s_ext;
          g1_d  = g1_next(g1_q);
          g2_d  = g2_next(g2_q);
        end else if (!issue) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (load) begin
          if (sum_ext > SAT_HI) begin
            corr_d = CORR_W'(CORR_MAX);
          end else if (sum_ext < SAT_LO) begin
            corr_d = CORR_W'(CORR_MIN);
          end else begin
            corr_d = sum_ext[CORR_W-1:0];
          end
          oph_d     = phase_q;
          det_d     = (sum_ext > thr_ext) || (sum_ext < -thr_ext);
          bit_d     = (sum_ext > thr_ext);
          out_vld_d = 1'b1;
          phase_d   = ring_inc(phase_q);
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      tap_first_q  <= TAP_FIRST_RST;
      tap_second_q <= TAP_SECOND_RST;
      thr_q        <= THR_RST;
      wp_q         <= '0;
      fill_q       <= '0;
      phase_q      <= '0;
      cnt_q        <= '0;
      rd_vld_q     <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      wp_q      <= wp_d;
      fill_q    <= fill_d;
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TAP_FIRST:  tap_first_q  <= cfg_data_i[TAP_W-1:0];
          CFG_TAP_SECOND: tap_second_q <= cfg_data_i[TAP_W-1:0];
          CFG_DETECT_THR: thr_q        <= cfg_data_i[THR_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q <= rd_addr_d;
    g1_q      <= g1_d;
    g2_q      <= g2_d;
    acc_q     <= acc_d;
    corr_q    <= corr_d;
    oph_q     <= oph_d;
    det_q     <= det_d;
    bit_q     <= bit_d;
  end

  assign result_if.valid       = out_vld_q;
  assign result_if.correlation = corr_q;
  assign result_if.code_phase  = oph_q;
  assign result_if.detected    = det_q;
  assign result_if.data_bit    = bit_q;

  `GCSC_ASSERT(a_fill_bound, clk_i, rst_ni, fill_q <= lfsr_t'(CODE_LEN), "fill count overran the ring")
  `GCSC_ASSERT(a_run_full, clk_i, rst_ni, (state_q != S_RUN) || (fill_q == lfsr_t'(CODE_LEN)), "correlation started on a part-filled ring")
  `GCSC_ASSERT(a_ptr_bound, clk_i, rst_ni, (wp_q < lfsr_t'(CODE_LEN)) && (phase_q < lfsr_t'(CODE_LEN)), "ring pointer or phase out of range")
  `GCSC_ASSERT(a_done_drained, clk_i, rst_ni, (state_q != S_DONE) || ((cnt_q == ISSUE_END) && !rd_vld_q), "finish reached before all chips accumulated")
  `GCSC_ASSERT_NEXT(a_load_valid, clk_i, rst_ni, load, out_vld_q && (state_q == S_IDLE), "finished result not presented")

endmodule

`default_nettype wire
